// File: hw/rtl/crp_pkg.sv
// Shared types and constants for the label resampler.
package crp_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int MAX_OUTCOMES = 256;
    localparam int COUNT_BITS   = 21;

    localparam logic [1:0] OP_WR_CLUSTER = 2'd0;
    localparam logic [1:0] OP_WR_COUNT   = 2'd1;
    localparam logic [1:0] OP_RESAMPLE   = 2'd2;

    localparam logic [2:0] REG_ALPHA    = 3'd0;
    localparam logic [2:0] REG_BETA     = 3'd1;
    localparam logic [2:0] REG_OUTCOMES = 3'd2;
    localparam logic [2:0] REG_CLUSTERS = 3'd3;
    localparam logic [2:0] REG_DATA     = 3'd4;

    localparam int DIV_W = 64;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage

// File: hw/rtl/crp_categorical_label_resampler.sv
// Top level of the categorical label resampler.
// Usage:
//   s_axis carries one word per op: tuser holds op, tdata the other fields.
//   Ops 0 and 1 load label/size and outcome count tables and give no result.
//   Op 2 resamples one point and gives one m_axis word (new label, fallback).
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle; it does not check.
// Timing:
//   Load ops are taken one per cycle while idle. A resample makes an
//   empty-count pass over the clusters in use, then a weight pass (per
//   cluster a read step, an operand step, two passes of the shared 80-step
//   divider for predictive and prior, a weight write), then the cumulative
//   pick, which stops at the first cluster whose running sum passes r*total.
//   s_axis_tready is low while an item is in work or a result waits, and
//   rises the cycle after the result is taken.
// Reset clears control state and the registers to their reset values; the
//   tables are undefined until written. A stalled receiver holds the result.
module crp_categorical_label_resampler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cluster_index, cluster_label, cluster_size, outcome_index, count_value,
    // old_label, datum, random_fraction, then zero fill
    input  logic [119:0] s_axis_tdata,
    // op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_label
    output logic [15:0] m_axis_tdata,
    // took_fallback
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import crp_pkg::*;

    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int OW = $clog2(MAX_OUTCOMES);
    localparam int CNTW = $clog2(MAX_CLUSTERS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EMPTY, S_COUNT, S_RD, S_PRED, S_PRIOR, S_MUL, S_WT, S_PICK_RD,
        S_PICK, S_OUT
    } state_t;

    state_t state_reg;
    logic [23:0] alpha_reg, beta_reg;
    logic [8:0]  kreg_reg;
    logic [6:0]  ncreg_reg;
    logic [20:0] nreg_reg;

    logic [15:0] label_mem [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] size_mem [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] cnt_mem [MAX_CLUSTERS*MAX_OUTCOMES];
    logic [31:0] wt_mem [MAX_CLUSTERS];

    logic [5:0]  in_ci;
    logic [15:0] in_lab, in_old, in_r;
    logic [20:0] in_sz, in_cv;
    logic [7:0]  in_oi, in_dat;
    assign in_ci  = s_axis_tdata[5:0];
    assign in_lab = s_axis_tdata[21:6];
    assign in_sz  = s_axis_tdata[42:22];
    assign in_oi  = s_axis_tdata[50:43];
    assign in_cv  = s_axis_tdata[71:51];
    assign in_old = s_axis_tdata[87:72];
    assign in_dat = s_axis_tdata[95:88];
    assign in_r   = s_axis_tdata[111:96];

    logic [15:0] old_reg, r_reg;
    logic [7:0]  dat_reg;
    logic [CNTW-1:0] nc_reg;
    logic [8:0]  k_reg;
    logic [CW-1:0] c_reg;
    logic [CNTW:0] empty_reg;
    logic [15:0] lab_q;
    logic [COUNT_BITS-1:0] sz_q, cnt_q;
    logic [31:0] wt_q;
    logic [31:0] pred_reg;
    logic [63:0] prod_reg;
    logic [39:0] total_reg, run_reg;
    logic [15:0] res_lab_reg;
    logic        res_fb_reg;
    logic        dat_ok_reg;
    div_req_t    dreq;
    div_rsp_t    drsp;

    crp_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = res_lab_reg;
    assign m_axis_tuser  = res_fb_reg;

    // Per-cluster operands
    logic        o_bit;
    logic [COUNT_BITS-1:0] so;
    logic [63:0] numv, denv, dd;
    logic        last_c;
    always_comb
    begin
        o_bit = (lab_q == old_reg);
        so    = (sz_q > COUNT_BITS'(o_bit)) ? sz_q - COUNT_BITS'(o_bit) : '0;
        numv  = 64'(beta_reg) + (64'(dat_ok_reg ? cnt_q : '0) << 16);
        numv  = (numv > (64'(o_bit) << 16)) ? numv - (64'(o_bit) << 16) : 64'd0;
        denv  = 64'(k_reg) * 64'(beta_reg) + (64'(so) << 16);
        dd    = 64'(alpha_reg) + (64'((nreg_reg > 21'd0) ? nreg_reg - 21'd1 : 21'd0) << 16);
        last_c = (CNTW'(c_reg) == nc_reg - CNTW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == OP_WR_CLUSTER && 32'(in_ci) < MAX_CLUSTERS)
        begin
            label_mem[in_ci[CW-1:0]] <= in_lab;
            size_mem[in_ci[CW-1:0]]  <= COUNT_BITS'(in_sz);
        end
        if (accept && s_axis_tuser == OP_WR_COUNT && 32'(in_ci) < MAX_CLUSTERS
            && 32'(in_oi) < MAX_OUTCOMES)
            cnt_mem[{in_ci[CW-1:0], in_oi[OW-1:0]}] <= COUNT_BITS'(in_cv);
        lab_q <= label_mem[c_reg];
        sz_q  <= size_mem[c_reg];
        cnt_q <= cnt_mem[{c_reg, dat_reg[OW-1:0]}];
        wt_q  <= wt_mem[c_reg];
        if (state_reg == S_WT)
            wt_mem[c_reg] <= (|prod_reg[63:48]) ? SAT32 : prod_reg[47:16];
    end

    always_comb
    begin
        dreq = '0;
        if (state_reg == S_RD)
        begin
            dreq.start = 1'b1;
            dreq.num = numv;
            dreq.den = denv;
        end
        else if (state_reg == S_PRED && drsp.done)
        begin
            dreq.start = 1'b1;
            if (sz_q > COUNT_BITS'(o_bit))
            begin
                dreq.num = 64'(so) << 16;
                dreq.den = dd;
            end
            else
            begin
                dreq.num = 64'(alpha_reg);
                dreq.den = 64'(empty_reg) * dd;
            end
        end
    end

    // prior for s>o is floor(65536*(so<<16)/D), for an empty cluster alpha/(E*D)
    logic [63:0] prior_fix;
    assign prior_fix = 64'(drsp.quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            alpha_reg   <= 24'd65536;
            beta_reg    <= 24'd65536;
            kreg_reg    <= 9'd256;
            ncreg_reg   <= 7'd1;
            nreg_reg    <= 21'd1;
            c_reg       <= '0;
            old_reg     <= '0;
            r_reg       <= '0;
            dat_reg     <= '0;
            dat_ok_reg  <= 1'b0;
            nc_reg      <= '0;
            k_reg       <= '0;
            empty_reg   <= '0;
            pred_reg    <= '0;
            prod_reg    <= '0;
            total_reg   <= '0;
            run_reg     <= '0;
            res_lab_reg <= '0;
            res_fb_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA:    alpha_reg <= cfg_data;
                    REG_BETA:     beta_reg  <= cfg_data;
                    REG_OUTCOMES: kreg_reg  <= cfg_data[8:0];
                    REG_CLUSTERS: ncreg_reg <= cfg_data[6:0];
                    REG_DATA:     nreg_reg  <= cfg_data[20:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_axis_tuser == OP_RESAMPLE)
                    begin
                        old_reg <= in_old;
                        r_reg   <= in_r;
                        dat_reg <= in_dat;
                        dat_ok_reg <= 32'(in_dat) < MAX_OUTCOMES;
                        nc_reg  <= (ncreg_reg == 7'd0) ? CNTW'(1) :
                                   (32'(ncreg_reg) > MAX_CLUSTERS) ? CNTW'(MAX_CLUSTERS)
                                   : CNTW'(ncreg_reg);
                        k_reg   <= (kreg_reg == 9'd0) ? 9'd1 :
                                   (32'(kreg_reg) > MAX_OUTCOMES) ? 9'(MAX_OUTCOMES)
                                   : kreg_reg;
                        empty_reg <= (CNTW+1)'(1);
                        total_reg <= '0;
                        c_reg   <= '0;
                        state_reg <= S_EMPTY;
                    end
                end
                S_EMPTY:
                begin
                    // lab_q/sz_q are registered reads at c_reg; advance on pair
                    state_reg <= S_COUNT;
                    c_reg <= c_reg;
                end
                S_COUNT:
                begin
                    if (lab_q == old_reg && sz_q == COUNT_BITS'(1))
                        empty_reg <= empty_reg + (CNTW+1)'(1);
                    if (last_c)
                    begin
                        c_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        c_reg <= c_reg + CW'(1);
                        state_reg <= S_EMPTY;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_PRED;
                end
                S_PRED:
                begin
                    if (drsp.done)
                    begin
                        pred_reg <= drsp.quo;
                        state_reg <= S_PRIOR;
                    end
                end
                S_PRIOR:
                begin
                    if (drsp.done)
                    begin
                        prod_reg  <= 64'(pred_reg) * prior_fix;
                        state_reg <= S_WT;
                    end
                end
                S_WT:
                begin
                    total_reg <= total_reg +
                        40'((|prod_reg[63:48]) ? SAT32 : prod_reg[47:16]);
                    if (last_c)
                    begin
                        c_reg <= '0;
                        run_reg <= '0;
                        state_reg <= S_PICK_RD;
                        res_fb_reg <= 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + CW'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_PICK_RD:
                begin
                    // wait for the registered wt_q and lab_q to follow c_reg
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    run_reg <= run_reg + 40'(wt_q);
                    if ((56'(run_reg + 40'(wt_q)) << 16) > 56'(total_reg) * 56'(r_reg))
                    begin
                        res_lab_reg <= lab_q;
                        res_fb_reg  <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                    else if (last_c)
                    begin
                        res_lab_reg <= lab_q;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_PICK_RD;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/crp_divider.sv
// Shared radix-2 divider: floor(num*65536/den), saturated to 32 bits, zero when den is zero.
module crp_divider
(
    input  logic             clk,
    input  logic             rst_n,
    input  crp_pkg::div_req_t req,
    output crp_pkg::div_rsp_t rsp
);
    import crp_pkg::*;

    localparam int STEPS = DIV_W + 16;

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [STEPS-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W+15:0] sh_reg, sh_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_W-1:0], sh_reg[DIV_W+15]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = '0;
            den_next  = req.den;
            sh_next   = {req.num, 16'd0};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next = {sh_reg[DIV_W+14:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (den_reg == '0) ? 32'd0 :
                      (|quo_reg[STEPS-1:32]) ? SAT32 : quo_reg[31:0];
endmodule

// File: hw/rtl/crp_checker.sv
// Port-level checks for the label resampler, bound to the top level.
module crp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result waits");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser)) else $error("result dropped");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("not idle");
endmodule

bind crp_categorical_label_resampler crp_checker u_chk (.*);
